FILE: rtl/core/rsaepg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsaepg_pkg
// Shared types, widths and the small prime table of the exponent pair generator.
// ----------------------------------------------------------------------------
package rsaepg_pkg;

   localparam int PRIME_BITS = 16;
   localparam int IN_W       = 16;
   localparam int OUT_W      = 32;
   // factor bits actually used: low PRIME_BITS bits of each 16-bit field
   localparam int FACT_W     = (PRIME_BITS < IN_W) ? PRIME_BITS : IN_W;
   localparam int PHI_W      = 2 * FACT_W;
   localparam int CNT_W      = $clog2(PHI_W);
   localparam int E_W        = 6;
   localparam int NUM_PRIMES = 18;
   localparam int IDX_W      = $clog2(NUM_PRIMES + 1);

   typedef struct packed {
      logic [IN_W-1:0] prime_a;
      logic [IN_W-1:0] prime_b;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] public_exponent;
      logic [OUT_W-1:0] private_exponent;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [E_W-1:0]   divisor;
      logic [PHI_W-1:0] dividend;
   } div_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [PHI_W-1:0] quotient;
      logic [E_W-1:0]   remainder;
   } div_stat_type;

   // primes up to 64, in rising order
   function automatic logic [E_W-1:0] prime_at(input logic [IDX_W-1:0] idx);
      logic [E_W-1:0] p;
      case (idx)
         5'd0:    p = 6'd2;
         5'd1:    p = 6'd3;
         5'd2:    p = 6'd5;
         5'd3:    p = 6'd7;
         5'd4:    p = 6'd11;
         5'd5:    p = 6'd13;
         5'd6:    p = 6'd17;
         5'd7:    p = 6'd19;
         5'd8:    p = 6'd23;
         5'd9:    p = 6'd29;
         5'd10:   p = 6'd31;
         5'd11:   p = 6'd37;
         5'd12:   p = 6'd41;
         5'd13:   p = 6'd43;
         5'd14:   p = 6'd47;
         5'd15:   p = 6'd53;
         5'd16:   p = 6'd59;
         5'd17:   p = 6'd61;
         default: p = 6'd0;
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/core/rsa_exponent_pair_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_exponent_pair_generator
// Forms phi = (a-1)(b-1), picks the smallest table prime below phi that is coprime to
// phi and its modular inverse as the private exponent; if none fits, both are zero.
// ----------------------------------------------------------------------------
// One item is taken at a time; req_ready is high only while the sequencer is
// idle. An item goes through acceptance and the multiply for phi, then one
// division per prime tried in the shared bit-serial divider, then the inverse
// search over k below e and a load of the result, e being the chosen exponent.
// At the default width at most ten primes are tried, since only the primes up
// to 23 can all divide phi, so e is at most 29. Loading waits while an earlier
// result is still held. The result sits in an output register, so the next
// item may be accepted while it waits.
module rsa_exponent_pair_generator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rsaepg_pkg::req_type    req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsaepg_pkg::rsp_type    rsp_data
);
   import rsaepg_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PHI    = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_INV    = 3'd4;
   localparam logic [2:0] S_HOLD   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [FACT_W-1:0] am1_ff, am1_in;
   logic [FACT_W-1:0] bm1_ff, bm1_in;
   logic [PHI_W-1:0]  phi_ff, phi_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [E_W-1:0]    e_ff, e_in;
   logic [PHI_W-1:0]  pq_ff, pq_in;
   logic [E_W-1:0]    pr_ff, pr_in;
   logic [E_W-1:0]    k_ff, k_in;
   logic [E_W-1:0]    lowmod_ff, lowmod_in;
   logic [E_W-1:0]    lowq_ff, lowq_in;
   logic [PHI_W-1:0]  kpq_ff, kpq_in;
   logic [PHI_W-1:0]  d_ff, d_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [FACT_W-1:0] a_use, b_use;
   logic [E_W-1:0]    cand;
   logic [E_W:0]      lowsum;
   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;

   rsaepg_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign a_use  = req_data.prime_a[FACT_W-1:0];
   assign b_use  = req_data.prime_b[FACT_W-1:0];
   assign cand   = prime_at(idx_ff);
   assign lowsum = {1'b0, lowmod_ff} + {1'b0, pr_ff};

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      am1_in       = am1_ff;
      bm1_in       = bm1_ff;
      phi_in       = phi_ff;
      idx_in       = idx_ff;
      e_in         = e_ff;
      pq_in        = pq_ff;
      pr_in        = pr_ff;
      k_in         = k_ff;
      lowmod_in    = lowmod_ff;
      lowq_in      = lowq_ff;
      kpq_in       = kpq_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.divisor  = cand;
      div_ctrl.dividend = phi_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // zero factor saturates to zero
               am1_in   = (a_use == '0) ? '0 : a_use - 1'b1;
               bm1_in   = (b_use == '0) ? '0 : b_use - 1'b1;
               state_in = S_PHI;
            end
         end
         S_PHI: begin
            phi_in   = PHI_W'(am1_ff * bm1_ff);
            idx_in   = '0;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (idx_ff == IDX_W'(NUM_PRIMES) || PHI_W'(cand) >= phi_ff) begin
               e_in     = '0;
               d_in     = '0;
               state_in = S_HOLD;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               if (div_stat.remainder != '0) begin
                  // prime does not divide phi, so it is coprime
                  e_in      = cand;
                  pq_in     = div_stat.quotient;
                  pr_in     = div_stat.remainder;
                  k_in      = '0;
                  lowmod_in = E_W'(1);
                  lowq_in   = '0;
                  kpq_in    = '0;
                  state_in  = S_INV;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SEARCH;
               end
            end
         end
         S_INV: begin
            // track k*pr + 1 as lowq*e + lowmod, and k*pq alongside
            if (lowmod_ff == '0) begin
               d_in     = kpq_ff + PHI_W'(lowq_ff);
               state_in = S_HOLD;
            end else if (k_ff == e_ff - 1'b1) begin
               d_in     = '0;
               state_in = S_HOLD;
            end else begin
               if (lowsum >= {1'b0, e_ff}) begin
                  lowmod_in = E_W'(lowsum - {1'b0, e_ff});
                  lowq_in   = lowq_ff + 1'b1;
               end else begin
                  lowmod_in = E_W'(lowsum);
               end
               kpq_in = kpq_ff + pq_ff;
               k_in   = k_ff + 1'b1;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_in.public_exponent        = OUT_W'(e_ff);
               rsp_in.private_exponent       = OUT_W'(d_ff);
               state_in                      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      am1_ff    <= am1_in;
      bm1_ff    <= bm1_in;
      phi_ff    <= phi_in;
      idx_ff    <= idx_in;
      e_ff      <= e_in;
      pq_ff     <= pq_in;
      pr_ff     <= pr_in;
      k_ff      <= k_in;
      lowmod_ff <= lowmod_in;
      lowq_ff   <= lowq_in;
      kpq_ff    <= kpq_in;
      d_ff      <= d_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTH
   a_div_start_in_search : assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> state_ff == S_SEARCH)
      else $error("divider started outside the search state");

   a_inv_state_sane : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INV |-> (e_ff >= E_W'(2)) && (lowmod_ff < e_ff) && (pr_ff != '0))
      else $error("inverse search running on a bad exponent or residue");

   a_pair_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_ff.public_exponent == '0) == (rsp_ff.private_exponent == '0)))
      else $error("exponent pair not consistently zero");

   a_load_from_hold : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_HOLD)
      else $error("result register loaded outside the hold state");
`endif

endmodule

FILE: rtl/core/rsaepg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsaepg_div
// Bit-serial restoring divider: wide dividend by a small divisor, one
// quotient bit per cycle through a single compare-subtract.
// ----------------------------------------------------------------------------
module rsaepg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  rsaepg_pkg::div_ctrl_type   ctrl,
   output rsaepg_pkg::div_stat_type   stat
);
   import rsaepg_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PHI_W-1:0] sh_ff, sh_in;
   logic [PHI_W-1:0] quo_ff, quo_in;
   logic [E_W-1:0]   rem_ff, rem_in;
   logic [E_W-1:0]   dvs_ff, dvs_in;

   logic [E_W:0]     trial;
   logic             fits;

   assign trial = {rem_ff, sh_ff[PHI_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PHI_W - 1);
         sh_in   = ctrl.dividend;
         quo_in  = '0;
         rem_in  = '0;
         dvs_in  = ctrl.divisor;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[PHI_W-2:0], 1'b0};
         quo_in = {quo_ff[PHI_W-2:0], fits};
         rem_in = fits ? E_W'(trial - {1'b0, dvs_ff}) : E_W'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule
